// ===== rtl/vfu_pkg.sv =====
// Package for the scanline video upscaler: transaction payload types,
// scaling mode codes and default geometry. It depends on nothing else.
`timescale 1ns / 1ps

package vfu_pkg;

  localparam int SRC_WIDTH_DEF = 640;
  localparam int PIX_BITS = 32;
  localparam int RGB_BITS = 24;

  localparam logic [2:0] MODE_PASS   = 3'd0;
  localparam logic [2:0] MODE_BLEND  = 3'd1;
  localparam logic [2:0] MODE_DOUBLE = 3'd2;
  localparam logic [2:0] MODE_WIDE   = 3'd3;
  localparam logic [2:0] MODE_TRIPLE = 3'd4;

  typedef struct packed {
    logic [9:0]          src_x;
    logic [8:0]          src_y;
    logic [PIX_BITS-1:0] src_pixel;
  } src_t;

  typedef struct packed {
    logic [10:0]         dst_x;
    logic [9:0]          dst_y;
    logic [PIX_BITS-1:0] dst_pixel;
    logic                last_of_item;
  } dst_t;

endpackage

// ===== rtl/video_frame_upscaler_unit.sv =====
// Top level of the scanline video upscaler: input stage, result sequencer
// and output register. It depends on vfu_pkg and vfu_ram.
// An accepted pixel is held in the input stage; its results go out through the output register.
// While dst_ready allows, one result leaves per cycle; a pixel gives 1, 2, 4 or 6
// results by mode and parity on the single port; a new pixel enters with its last result.
// Reset clears the mode, all valid flags and the previous pixel.
// The previous-line store is not cleared and holds garbage until written.
`timescale 1ns / 1ps

module video_frame_upscaler_unit #(
  parameter int SRC_WIDTH = vfu_pkg::SRC_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  input  logic          src_valid,
  output logic          src_ready,
  input  vfu_pkg::src_t src,
  output logic          dst_valid,
  input  logic          dst_ready,
  output vfu_pkg::dst_t dst
);

  import vfu_pkg::*;

  localparam int AW = $clog2(SRC_WIDTH);

  logic [2:0]          scale_mode;
  logic [RGB_BITS-1:0] previous_pixel;
  src_t                s1;
  logic                s1_valid;
  logic                s1_oob;
  logic [2:0]          s1_cnt;
  logic [2:0]          s1_num;
  logic                s1_last;
  logic                adv;
  logic                accept;
  logic                ram_we;
  logic                ram_re;
  logic [RGB_BITS-1:0] ram_rdata;
  logic [RGB_BITS-1:0] line_above;
  dst_t                res;

  function automatic logic [PIX_BITS-1:0] blend(input logic [RGB_BITS-1:0] a,
                                                input logic [PIX_BITS-1:0] b);
    logic [PIX_BITS-1:0] r;
    logic [8:0]          s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, a[i*8 +: 8]} + {1'b0, b[i*8 +: 8]};
      r[i*8 +: 8] = s[8:1];
    end
    return r;
  endfunction

  assign adv       = !dst_valid || dst_ready;
  assign s1_last   = (s1_cnt == s1_num - 3'd1);
  assign src_ready = !s1_valid || (adv && s1_last);
  assign accept    = src_valid && src_ready;

  assign ram_we = accept && (scale_mode == MODE_BLEND) && !src.src_y[0]
                  && (32'(src.src_x) < SRC_WIDTH);
  assign ram_re = accept && (scale_mode == MODE_BLEND) && src.src_y[0];

  vfu_ram #(
    .WIDTH(RGB_BITS),
    .DEPTH(SRC_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(src.src_x)),
    .wdata(src.src_pixel[RGB_BITS-1:0]),
    .re   (ram_re),
    .raddr(AW'(src.src_x)),
    .rdata(ram_rdata)
  );

  assign line_above = s1_oob ? '0 : ram_rdata;

  always_comb begin
    unique case (scale_mode)
      MODE_BLEND:  s1_num = s1.src_y[0] ? 3'd2 : 3'd1;
      MODE_DOUBLE: s1_num = 3'd2;
      MODE_WIDE:   s1_num = s1.src_x[0] ? 3'd4 : 3'd2;
      MODE_TRIPLE: s1_num = 3'd6;
      default:     s1_num = 3'd1;
    endcase
  end

  always_comb begin
    logic [9:0]  yb;
    logic [9:0]  y2;
    logic [9:0]  y3;
    logic [10:0] xb;
    logic [10:0] x1;
    logic [10:0] x2;
    yb = 10'(s1.src_y[8:1]) * 10'd3;
    y2 = {s1.src_y, 1'b0};
    y3 = 10'(s1.src_y) * 10'd3;
    xb = 11'(s1.src_x[9:1]) * 11'd3;
    x1 = 11'(s1.src_x);
    x2 = {s1.src_x, 1'b0};
    res.dst_x        = x1;
    res.dst_y        = 10'(s1.src_y);
    res.dst_pixel    = s1.src_pixel;
    res.last_of_item = s1_last;
    unique case (scale_mode)
      MODE_BLEND: begin
        if (!s1.src_y[0]) begin
          res.dst_y = yb;
        end else if (s1_cnt == 3'd0) begin
          res.dst_y     = yb + 10'd1;
          res.dst_pixel = blend(line_above, s1.src_pixel);
        end else begin
          res.dst_y = yb + 10'd2;
        end
      end
      MODE_DOUBLE: begin
        res.dst_y = y2 | 10'(s1_cnt[0]);
        if (s1_cnt[0]) begin
          res.dst_pixel = '0;
        end
      end
      MODE_WIDE: begin
        if (!s1.src_x[0]) begin
          res.dst_x = xb;
          res.dst_y = y2 | 10'(s1_cnt[0]);
          if (s1_cnt[0]) begin
            res.dst_pixel = '0;
          end
        end else begin
          res.dst_x = xb + (s1_cnt[0] ? 11'd2 : 11'd1);
          res.dst_y = y2 | 10'(s1_cnt[1]);
          if (s1_cnt[1]) begin
            res.dst_pixel = '0;
          end else if (!s1_cnt[0]) begin
            res.dst_pixel = blend(previous_pixel, s1.src_pixel);
          end
        end
      end
      MODE_TRIPLE: begin
        res.dst_x = x2 | 11'(s1_cnt[0]);
        case (s1_cnt)
          3'd0, 3'd1: res.dst_y = y3;
          3'd2, 3'd3: res.dst_y = y3 + 10'd1;
          default: begin
            res.dst_y     = y3 + 10'd2;
            res.dst_pixel = '0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_mode     <= MODE_PASS;
      previous_pixel <= '0;
      s1_valid       <= 1'b0;
      s1_cnt         <= '0;
      dst_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_mode <= cfg_data;
      end
      if (accept && (scale_mode == MODE_WIDE) && !src.src_x[0]) begin
        previous_pixel <= src.src_pixel[RGB_BITS-1:0];
      end
      if (accept) begin
        s1_valid <= 1'b1;
        s1_cnt   <= '0;
      end else if (s1_valid && adv) begin
        if (s1_last) begin
          s1_valid <= 1'b0;
        end else begin
          s1_cnt <= s1_cnt + 3'd1;
        end
      end
      if (adv) begin
        dst_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1     <= src;
      s1_oob <= (32'(src.src_x) >= SRC_WIDTH);
    end
    if (adv && s1_valid) begin
      dst <= res;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (s1_cnt < s1_num))
    else $error("result counter ran past the result count");

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("line store read and written in the same cycle");

  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_ready && !dst.last_of_item) |=> dst_valid)
    else $error("gap inside the results of one pixel");

  a_cnt_advance: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_cnt != 3'd0) |-> $past(s1_valid))
    else $error("result counter nonzero without a held pixel");

endmodule

// ===== rtl/vfu_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps

module vfu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 640
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
